/* hw/rtl/dur_pkg.sv */
// Shared types, constants and helpers for the depth undistort remap block.
// No dependencies; imported by dur_div, depth_undistort_remap_top and the testbench.
`timescale 1ns / 1ps
`default_nettype none

package dur_pkg;

  // pipelined divider: one quotient bit per stage, plus entry and exit stages
  localparam int DIV_STEPS = 32;
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam int MAG_W     = 33;

  typedef logic signed [30:0] ofs_t;   // normalised offset, Q.28, +-2.0
  typedef logic signed [31:0] q28_t;   // Q4.28

  localparam logic [29:0] OFS_LIMIT = 30'h2000_0000;
  localparam q28_t        ONE_Q28   = 32'sh1000_0000;

  typedef enum logic [2:0] {
    REG_FOCAL_X,
    REG_FOCAL_Y,
    REG_CENTRE_X,
    REG_CENTRE_Y,
    REG_RADIAL_K1,
    REG_RADIAL_K2,
    REG_RADIAL_K3,
    REG_TANGENTIAL
  } cfg_idx_t;

  function automatic q28_t sat32(input logic signed [63:0] v);
    q28_t r;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < 64'shFFFF_FFFF_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/dur_div.sv */
// Pipelined restoring divider: offset = sign * min(mag * 2^28 / focal, 2.0).
// Depends on dur_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dur_div
  import dur_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [MAG_W-1:0] mag,
  input  logic             neg,
  input  logic [31:0]      focal,
  output ofs_t             ofs
);

  logic [31:0]        rem  [0:DIV_STEPS];
  logic [31:0]        quo  [0:DIV_STEPS];
  logic [3:0]         low  [0:DIV_STEPS];
  logic [DIV_STEPS:0] sat_p;
  logic [DIV_STEPS:0] zero_p;
  logic [DIV_STEPS:0] neg_p;
  logic [29:0]        mag_o;

  // entry: quotient of 2^32 or more saturates anyway
  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]    <= {3'b0, mag[MAG_W-1:4]};
      low[0]    <= mag[3:0];
      quo[0]    <= '0;
      sat_p[0]  <= {3'b0, mag} >= {focal, 4'b0};
      zero_p[0] <= (mag == '0);
      neg_p[0]  <= neg;
    end
  end

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
    logic [32:0] trial;
    logic [32:0] diff;
    logic        ge;
    assign trial = {rem[j], low[j][3]};
    assign diff  = trial - {1'b0, focal};
    assign ge    = trial >= {1'b0, focal};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[j+1]    <= ge ? diff[31:0] : trial[31:0];
        quo[j+1]    <= {quo[j][30:0], ge};
        low[j+1]    <= {low[j][2:0], 1'b0};
        sat_p[j+1]  <= sat_p[j];
        zero_p[j+1] <= zero_p[j];
        neg_p[j+1]  <= neg_p[j];
      end
    end
  end

  always_comb begin
    if (zero_p[DIV_STEPS]) begin
      mag_o = '0;
    end else if (sat_p[DIV_STEPS] || quo[DIV_STEPS] > {2'b0, OFS_LIMIT}) begin
      mag_o = OFS_LIMIT;
    end else begin
      mag_o = quo[DIV_STEPS][29:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ofs <= neg_p[DIV_STEPS] ? -$signed({1'b0, mag_o}) : $signed({1'b0, mag_o});
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/depth_undistort_remap_top.sv */
// Depth undistort remap: Brown-Conrady lens model applied to one depth pixel.
// Depends on dur_pkg and dur_div.
//
// Usage:
//  - Input channel (in_valid/in_ready) carries one pixel per beat: src_col,
//    src_row, depth_mm. Output channel (out_valid/out_ready) carries one
//    result beat per input: dest_col, dest_row, depth_out, in_range.
//    Pixels whose target falls outside the frame come out with in_range low
//    and all other fields zero; the consumer drops them.
//  - Config port: cfg_we/cfg_idx/cfg_data, one register per write, taken
//    immediately. Write only when the pipeline is empty.
//  - Throughput: one pixel per clock while the output is not stalled. Input
//    beat to output beat runs through the per-axis divider (one quotient bit
//    per stage) and stages of one multiply or one add/saturate each.
//  - Stall: the whole pipeline advances on a single enable. When the output
//    register holds a beat that is not taken, every stage holds and in_ready
//    drops; bubbles in the pipeline still travel while the output is free.
//  - Reset (rst, synchronous): empties the pipeline and loads the default
//    camera parameters (zero distortion).
`timescale 1ns / 1ps
`default_nettype none

module depth_undistort_remap_top
  import dur_pkg::*;
#(
  parameter int FRAME_WIDTH  = 512,
  parameter int FRAME_HEIGHT = 424
) (
  input  logic        clk,
  input  logic        rst,
  // config
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [47:0] cfg_data,
  // pixel in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [8:0]  src_col,
  input  logic [8:0]  src_row,
  input  logic [15:0] depth_mm,
  // result out
  output logic        out_valid,
  input  logic        out_ready,
  output logic [8:0]  dest_col,
  output logic [8:0]  dest_row,
  output logic [15:0] depth_out,
  output logic        in_range
);

  localparam int LAT = 1 + DIV_LAT + 12;   // stages ahead of the output register
  localparam logic [22:0] W_LIM = 23'(FRAME_WIDTH);
  localparam logic [22:0] H_LIM = 23'(FRAME_HEIGHT);
  localparam logic signed [38:0] HALF_Q16 = 39'sd32768;
  localparam logic signed [38:0] NEG_ONE_Q16 = -39'sd65536;

  // ---------------- config registers ----------------
  logic [31:0]        focal_x;
  logic [31:0]        focal_y;
  logic [31:0]        centre_x;
  logic [31:0]        centre_y;
  q28_t               radial_k1;
  q28_t               radial_k2;
  q28_t               radial_k3;
  logic [47:0]        tangential;
  logic signed [23:0] p1;
  logic signed [23:0] p2;

  assign p1 = tangential[23:0];
  assign p2 = tangential[47:24];

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x    <= 32'd23920640;
      focal_y    <= 32'd23920640;
      centre_x   <= 32'd16777216;
      centre_y   <= 32'd13893632;
      radial_k1  <= '0;
      radial_k2  <= '0;
      radial_k3  <= '0;
      tangential <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_idx))
        REG_FOCAL_X:    focal_x    <= cfg_data[31:0];
        REG_FOCAL_Y:    focal_y    <= cfg_data[31:0];
        REG_CENTRE_X:   centre_x   <= cfg_data[31:0];
        REG_CENTRE_Y:   centre_y   <= cfg_data[31:0];
        REG_RADIAL_K1:  radial_k1  <= cfg_data[31:0];
        REG_RADIAL_K2:  radial_k2  <= cfg_data[31:0];
        REG_RADIAL_K3:  radial_k3  <= cfg_data[31:0];
        REG_TANGENTIAL: tangential <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------- pipeline control ----------------
  logic           en;
  logic [LAT-1:0] vld;
  logic [15:0]    dep [0:LAT-1];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dep[0] <= depth_mm;
      for (int i = 1; i < LAT; i++) begin
        dep[i] <= dep[i-1];
      end
    end
  end

  // ---------------- T0: offset from centre, split into sign and magnitude ----------------
  logic [33:0]      sub_xp, sub_xn, sub_yp, sub_yn;
  logic [MAG_W-1:0] mag_x, mag_y;
  logic             neg_x, neg_y;

  assign sub_xp = {9'b0, src_col, 16'b0} - {2'b0, centre_x};
  assign sub_xn = {2'b0, centre_x} - {9'b0, src_col, 16'b0};
  assign sub_yp = {9'b0, src_row, 16'b0} - {2'b0, centre_y};
  assign sub_yn = {2'b0, centre_y} - {9'b0, src_row, 16'b0};

  always_ff @(posedge clk) begin
    if (en) begin
      neg_x <= sub_xp[33];
      mag_x <= sub_xp[33] ? sub_xn[32:0] : sub_xp[32:0];
      neg_y <= sub_yp[33];
      mag_y <= sub_yp[33] ? sub_yn[32:0] : sub_yp[32:0];
    end
  end

  // ---------------- divider: dx, dy ----------------
  ofs_t dx, dy;

  dur_div u_div_x (.clk, .en, .mag(mag_x), .neg(neg_x), .focal(focal_x), .ofs(dx));
  dur_div u_div_y (.clk, .en, .mag(mag_y), .neg(neg_y), .focal(focal_y), .ofs(dy));

  // ---------------- M1: squares and cross term ----------------
  logic signed [61:0] pxx, pyy, pxy;
  logic [30:0]        dx2, dy2;
  logic signed [32:0] dxdy2_1, dxdy2_2;
  ofs_t               dx_d [0:7];
  ofs_t               dy_d [0:7];

  assign pxx = dx * dx;
  assign pyy = dy * dy;
  assign pxy = dx * dy;

  always_ff @(posedge clk) begin
    if (en) begin
      dx2     <= pxx[58:28];
      dy2     <= pyy[58:28];
      dxdy2_1 <= pxy[59:27];          // 2*dx*dy, floored
      dx_d[0] <= dx;
      dy_d[0] <= dy;
      for (int i = 1; i < 8; i++) begin
        dx_d[i] <= dx_d[i-1];
        dy_d[i] <= dy_d[i-1];
      end
    end
  end

  // ---------------- M2: r2 and tangential radii ----------------
  logic [31:0] r2_d [0:4];
  logic [32:0] sx, sy;                 // r2 + 2*dx2, r2 + 2*dy2

  always_ff @(posedge clk) begin
    if (en) begin
      r2_d[0] <= {1'b0, dx2} + {1'b0, dy2};
      for (int i = 1; i < 5; i++) begin
        r2_d[i] <= r2_d[i-1];
      end
      sx      <= {2'b0, dx2} + {1'b0, dx2, 1'b0} + {2'b0, dy2};
      sy      <= {2'b0, dy2} + {1'b0, dy2, 1'b0} + {2'b0, dx2};
      dxdy2_2 <= dxdy2_1;
    end
  end

  // ---------------- M3: k3*r2 and tangential products ----------------
  logic signed [64:0] pk_full;
  logic signed [57:0] tpx_full, tpy_full;
  logic signed [56:0] tqx_full, tqy_full;
  logic signed [36:0] pk3;
  logic signed [35:0] tpx, tpy;
  logic signed [34:0] tqx, tqy;

  assign pk_full  = radial_k3 * $signed({1'b0, r2_d[0]});
  assign tpx_full = p2 * $signed({1'b0, sx});
  assign tpy_full = p1 * $signed({1'b0, sy});
  assign tqx_full = p1 * dxdy2_2;
  assign tqy_full = p2 * dxdy2_2;

  always_ff @(posedge clk) begin
    if (en) begin
      pk3 <= pk_full[64:28];
      tpx <= tpx_full[57:22];
      tpy <= tpy_full[57:22];
      tqx <= tqx_full[56:22];
      tqy <= tqy_full[56:22];
    end
  end

  // ---------------- M4..M8: Horner chain for kr ----------------
  q28_t               a_q, b_q, kr;
  logic signed [36:0] tan_x_d [0:5];
  logic signed [36:0] tan_y_d [0:5];
  logic signed [64:0] pa_full, pb_full;
  logic signed [36:0] pa, pb;

  assign pa_full = a_q * $signed({1'b0, r2_d[2]});
  assign pb_full = b_q * $signed({1'b0, r2_d[4]});

  always_ff @(posedge clk) begin
    if (en) begin
      a_q        <= sat32(64'(pk3) + 64'(radial_k2));
      tan_x_d[0] <= 37'(tpx) + 37'(tqx);
      tan_y_d[0] <= 37'(tpy) + 37'(tqy);
      for (int i = 1; i < 6; i++) begin
        tan_x_d[i] <= tan_x_d[i-1];
        tan_y_d[i] <= tan_y_d[i-1];
      end
      pa <= pa_full[64:28];
      b_q <= sat32(64'(pa) + 64'(radial_k1));
      pb <= pb_full[64:28];
      kr <= sat32(64'(ONE_Q28) + 64'(pb));
    end
  end

  // ---------------- M9..M12: distorted position, back to pixels ----------------
  logic signed [62:0] mx_full, my_full;
  logic signed [34:0] mx, my;
  q28_t               ux, uy;
  logic signed [64:0] fx_full, fy_full;
  logic signed [36:0] fx, fy;
  logic signed [38:0] tx, ty;          // position + one half, Q16

  assign mx_full = dx_d[7] * kr;
  assign my_full = dy_d[7] * kr;
  assign fx_full = $signed({1'b0, focal_x}) * ux;
  assign fy_full = $signed({1'b0, focal_y}) * uy;

  always_ff @(posedge clk) begin
    if (en) begin
      mx <= mx_full[62:28];
      my <= my_full[62:28];
      ux <= sat32(64'(mx) + 64'(tan_x_d[5]));
      uy <= sat32(64'(my) + 64'(tan_y_d[5]));
      fx <= fx_full[64:28];
      fy <= fy_full[64:28];
      tx <= 39'(fx) + $signed({7'b0, centre_x}) + HALF_Q16;
      ty <= 39'(fy) + $signed({7'b0, centre_y}) + HALF_Q16;
    end
  end

  // ---------------- output: truncate toward zero, range check ----------------
  // a negative sum above -1.0 truncates to pixel 0, still inside the frame
  logic ok_x, ok_y, ok;

  assign ok_x = tx[38] ? (tx > NEG_ONE_Q16) : (tx[38:16] < W_LIM);
  assign ok_y = ty[38] ? (ty > NEG_ONE_Q16) : (ty[38:16] < H_LIM);
  assign ok   = ok_x && ok_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_range  <= ok;
      dest_col  <= (ok && !tx[38]) ? tx[24:16] : '0;
      dest_row  <= (ok && !ty[38]) ? ty[24:16] : '0;
      depth_out <= ok ? dep[LAT-1] : '0;
    end
  end

  // ---------------- checks ----------------
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !in_range |-> dest_col == '0 && dest_row == '0 && depth_out == '0)
    else $error("dropped pixel carries non-zero fields");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !in_ready |=> $stable(vld))
    else $error("pipeline moved during output stall");

  a_dest_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_range |-> dest_col < FRAME_WIDTH && dest_row < FRAME_HEIGHT)
    else $error("in-range destination outside frame");

endmodule

`default_nettype wire

/* test/depth_undistort_remap_top_tb.sv */
// Testbench for depth_undistort_remap_top: lens remap results are checked
// against a fixed-point predictor held in a small scoreboard class.
// Depends on dur_pkg and the block's RTL.
`timescale 1ns / 1ps

module depth_undistort_remap_top_tb
  import dur_pkg::*;
();

  localparam int FRAME_W   = 512;
  localparam int FRAME_H   = 424;
  localparam int IDLE_PCT  = 29;
  localparam int STALL_MAX = 4000;   // cycles with no beat on either side

  typedef struct packed {
    logic [8:0]  col;
    logic [8:0]  row;
    logic [15:0] depth;
    logic        ok;
  } remap_res_t;

  // Scoreboard: keeps its own copy of the camera registers and a queue of
  // the remap results still owed by the block.
  class remap_board;
    logic [47:0] cam_reg [8];
    remap_res_t  owed [$];
    int          errors;

    function new();
      cam_reg[REG_FOCAL_X]   = 48'd23920640;
      cam_reg[REG_FOCAL_Y]   = 48'd23920640;
      cam_reg[REG_CENTRE_X]  = 48'd16777216;
      cam_reg[REG_CENTRE_Y]  = 48'd13893632;
      cam_reg[REG_RADIAL_K1] = '0;
      cam_reg[REG_RADIAL_K2] = '0;
      cam_reg[REG_RADIAL_K3] = '0;
      cam_reg[REG_TANGENTIAL] = '0;
      errors = 0;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [47:0] val);
      cam_reg[idx] = (idx == REG_TANGENTIAL) ? val : {16'd0, val[31:0]};
    endfunction

    function longint clip(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    // offset from the principal point over focal length, Q.28, +-2.0
    function longint offset_q28(logic [8:0] pix, logic [31:0] ctr, logic [31:0] foc);
      longint num, f, q;
      num = 0;
      f = 0;
      num[24:0] = {pix, 16'd0};
      f[31:0] = ctr;
      num = num - f;
      f[31:0] = foc;
      if (foc == 0) begin
        if (num > 0) return 64'sd536870912;
        if (num < 0) return -64'sd536870912;
        return 0;
      end
      q = (num * 64'sd268435456) / f;
      if (q > 64'sd536870912) q = 64'sd536870912;
      if (q < -64'sd536870912) q = -64'sd536870912;
      return q;
    endfunction

    function longint round_half(longint pos);
      longint t;
      t = pos + 64'sd32768;
      if (t >= 0) return t >>> 16;
      return -((-t) >>> 16);
    endfunction

    function remap_res_t remap(logic [8:0] col, logic [8:0] row, logic [15:0] depth);
      longint fx, fy, cx, cy, k1, k2, k3, p1, p2;
      longint dx, dy, dx2, dy2, r2, dxdy2, a, b, kr, ux, uy, px, py, ix, iy;
      remap_res_t r;
      fx = 0; fy = 0; cx = 0; cy = 0;
      fx[31:0] = cam_reg[REG_FOCAL_X][31:0];
      fy[31:0] = cam_reg[REG_FOCAL_Y][31:0];
      cx[31:0] = cam_reg[REG_CENTRE_X][31:0];
      cy[31:0] = cam_reg[REG_CENTRE_Y][31:0];
      k1 = longint'(signed'(cam_reg[REG_RADIAL_K1][31:0]));
      k2 = longint'(signed'(cam_reg[REG_RADIAL_K2][31:0]));
      k3 = longint'(signed'(cam_reg[REG_RADIAL_K3][31:0]));
      p1 = longint'(signed'(cam_reg[REG_TANGENTIAL][23:0]));
      p2 = longint'(signed'(cam_reg[REG_TANGENTIAL][47:24]));
      dx = offset_q28(col, cam_reg[REG_CENTRE_X][31:0], cam_reg[REG_FOCAL_X][31:0]);
      dy = offset_q28(row, cam_reg[REG_CENTRE_Y][31:0], cam_reg[REG_FOCAL_Y][31:0]);
      dx2 = (dx * dx) >>> 28;
      dy2 = (dy * dy) >>> 28;
      r2 = dx2 + dy2;
      dxdy2 = (2 * dx * dy) >>> 28;
      a = clip(((k3 * r2) >>> 28) + k2);
      b = clip(((a * r2) >>> 28) + k1);
      kr = clip(64'sd268435456 + ((b * r2) >>> 28));
      ux = clip(((dx * kr) >>> 28) + ((p2 * (r2 + 2 * dx2)) >>> 22)
                + ((p1 * dxdy2) >>> 22));
      uy = clip(((dy * kr) >>> 28) + ((p1 * (r2 + 2 * dy2)) >>> 22)
                + ((p2 * dxdy2) >>> 22));
      px = ((fx * ux) >>> 28) + cx;
      py = ((fy * uy) >>> 28) + cy;
      ix = round_half(px);
      iy = round_half(py);
      r = '0;
      if (ix >= 0 && ix < FRAME_W && iy >= 0 && iy < FRAME_H) begin
        r.col = ix[8:0];
        r.row = iy[8:0];
        r.depth = depth;
        r.ok = 1'b1;
      end
      return r;
    endfunction

    function void note_pixel(logic [8:0] col, logic [8:0] row, logic [15:0] depth);
      owed.push_back(remap(col, row, depth));
    endfunction

    function void check_result(remap_res_t got);
      remap_res_t exp;
      if (owed.size() == 0) begin
        $error("result beat with nothing outstanding");
        errors++;
        return;
      end
      exp = owed.pop_front();
      if (got.col !== exp.col) begin
        $error("dest_col: expected %0d, got %0d", exp.col, got.col);
        errors++;
      end
      if (got.row !== exp.row) begin
        $error("dest_row: expected %0d, got %0d", exp.row, got.row);
        errors++;
      end
      if (got.depth !== exp.depth) begin
        $error("depth_out: expected %0d, got %0d", exp.depth, got.depth);
        errors++;
      end
      if (got.ok !== exp.ok) begin
        $error("in_range: expected %0d, got %0d", exp.ok, got.ok);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [2:0]  cfg_idx;
  logic [47:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [8:0]  src_col;
  logic [8:0]  src_row;
  logic [15:0] depth_mm;
  logic        out_valid;
  logic        out_ready;
  logic [8:0]  dest_col;
  logic [8:0]  dest_row;
  logic [15:0] depth_out;
  logic        in_range;

  remap_board board;
  bit          calm;      // no idling on either side while set
  int          quiet;

  depth_undistort_remap_top #(
    .FRAME_WIDTH (FRAME_W),
    .FRAME_HEIGHT(FRAME_H)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .src_col  (src_col),
    .src_row  (src_row),
    .depth_mm (depth_mm),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .dest_col (dest_col),
    .dest_row (dest_row),
    .depth_out(depth_out),
    .in_range (in_range)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // register write, only issued with the pipeline drained
  task automatic write_cam(cfg_idx_t idx, logic [47:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = val;
    @(posedge clk);
    board.write_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // one pixel beat; valid held until in_ready is seen at an edge
  task automatic send_pixel(logic [8:0] col, logic [8:0] row, logic [15:0] depth);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    src_col = col;
    src_row = row;
    depth_mm = depth;
    do @(posedge clk); while (!in_ready);
    board.note_pixel(col, row, depth);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_camera(logic [31:0] fx, logic [31:0] fy, logic [31:0] cx,
                             logic [31:0] cy, logic [31:0] k1, logic [31:0] k2,
                             logic [31:0] k3, logic [47:0] tp);
    write_cam(REG_FOCAL_X, {16'd0, fx});
    write_cam(REG_FOCAL_Y, {16'd0, fy});
    write_cam(REG_CENTRE_X, {16'd0, cx});
    write_cam(REG_CENTRE_Y, {16'd0, cy});
    write_cam(REG_RADIAL_K1, {16'd0, k1});
    write_cam(REG_RADIAL_K2, {16'd0, k2});
    write_cam(REG_RADIAL_K3, {16'd0, k3});
    write_cam(REG_TANGENTIAL, tp);
  endtask

  // random signed value of at most 'bits' magnitude bits
  function automatic logic [31:0] small_coeff(int bits);
    logic [31:0] v;
    v = $urandom() & ((32'd1 << bits) - 1);
    return $urandom_range(1) ? -v : v;
  endfunction

  task automatic random_camera(int kind);
    logic [31:0] fx, fy, cx, cy;
    logic [23:0] p1, p2;
    case (kind)
      0: begin    // full-range registers
        load_camera($urandom(), $urandom(), $urandom(), $urandom(),
                    $urandom(), $urandom(), $urandom(), 48'({$urandom(), $urandom()}));
      end
      default: begin    // a plausible depth camera with mild distortion
        fx = 32'd16777216 + $urandom_range(32'd16777216);
        fy = 32'd16777216 + $urandom_range(32'd16777216);
        cx = 32'd14680064 + $urandom_range(32'd4194304);
        cy = 32'd11796480 + $urandom_range(32'd4194304);
        p1 = 24'(small_coeff(15));
        p2 = 24'(small_coeff(15));
        load_camera(fx, fy, cx, cy, small_coeff(26), small_coeff(25),
                    small_coeff(24), {p2, p1});
      end
    endcase
  endtask

  task automatic random_pixels(int count);
    for (int i = 0; i < count; i++) begin
      send_pixel(9'($urandom_range(FRAME_W - 1)), 9'($urandom_range(FRAME_H - 1)),
                 16'($urandom()));
    end
  endtask

  // result side: random back-pressure, checks at the rising edge
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      board.check_result('{dest_col, dest_row, depth_out, in_range});
    end
  end

  // watchdog: no beat on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_MAX) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    board = new();
    calm = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    src_col = '0;
    src_row = '0;
    depth_mm = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // default camera: frame corners and depth extremes
    send_pixel(9'd0, 9'd0, 16'd0);
    send_pixel(9'd511, 9'd0, 16'hFFFF);
    send_pixel(9'd0, 9'd423, 16'h5555);
    send_pixel(9'd511, 9'd423, 16'hAAAA);
    send_pixel(9'd256, 9'd212, 16'd1);
    drain();

    // zero focal lengths: offsets pinned at +-2.0 or zero
    load_camera(32'd0, 32'd0, 32'd16777216, 32'd13893632, '0, '0, '0, '0);
    send_pixel(9'd256, 9'd212, 16'd7);
    send_pixel(9'd0, 9'd0, 16'd8);
    send_pixel(9'd511, 9'd423, 16'd9);
    drain();

    // centre near the origin: targets just below zero round to column 0
    load_camera(32'd23920640, 32'd23920640, 32'd20000, 32'd30000, '0, '0, '0,
                {24'hFFF000, 24'hFFF800});
    send_pixel(9'd0, 9'd0, 16'd11);
    send_pixel(9'd1, 9'd0, 16'd12);
    send_pixel(9'd0, 9'd1, 16'd13);
    drain();

    // coefficient extremes and saturation; out-of-frame targets
    load_camera(32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h7FFF_FFFF, {24'h7FFFFF, 24'h800000});
    send_pixel(9'd0, 9'd0, 16'd21);
    send_pixel(9'd511, 9'd423, 16'd22);
    send_pixel(9'd100, 9'd300, 16'd23);
    drain();
    load_camera(32'd1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h8000_0000, {24'h800000, 24'h7FFFFF});
    send_pixel(9'd0, 9'd0, 16'd31);
    send_pixel(9'd511, 9'd423, 16'd32);
    send_pixel(9'd300, 9'd100, 16'd33);
    drain();

    // random phases; the sender waits for a full drain before each rewrite
    for (int ph = 0; ph < 9; ph++) begin
      random_camera((ph % 3 == 0) ? 0 : 1);
      calm = (ph == 4);
      random_pixels(205);
      calm = 1'b0;
      drain();
    end

    repeat (60) @(posedge clk);
    if (board.errors == 0 && board.owed.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
